// ===== hdl/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg: shared constants and types for the decimal square root block
// Default parameter values, fixed field widths and sequencer state codes.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int RADICAND_BITS_DEF = 31;
  localparam int MAX_PLACES_DEF    = 6;

  localparam int WHOLE_W    = 16;
  localparam int FRACTION_W = 20;
  localparam int PLACES_W   = 3;

  // iterations of the integer root, one root bit each
  localparam int ROOT_STEPS = 16;

  localparam logic [3:0] LAST_DIGIT = 4'd9;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROOT  = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_STEP  = 6'b001000,
    ST_NEXT  = 6'b010000,
    ST_DONE  = 6'b100000
  } dsr_state_t;

endpackage

// ===== hdl/decimal_square_root.sv =====
// ----------------------------------------------------------------------------
// decimal_square_root: truncated decimal square root
// Returns floor(sqrt(n)) and the first p decimal fraction digits of sqrt(n).
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result goes out. The result is shown for one cycle with out_valid
// and must be taken then, since the block cannot hold it. The sequencer
// first finds the integer root one bit at a time, then for each of the p
// places (values above MAX_PLACES count as MAX_PLACES) it runs a setup
// step, one trial per unit of the digit plus the failing trial (none after
// a nine), and an update step; the root bits and the digit trials share
// one subtract-and-compare unit. A last step sends the word out. busy falls
// in the out_valid cycle, so the next word can start there.
module decimal_square_root #(
  parameter int RADICAND_BITS = dsr_pkg::RADICAND_BITS_DEF,
  parameter int MAX_PLACES    = dsr_pkg::MAX_PLACES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [RADICAND_BITS-1:0]          in_radicand,
  input  logic [dsr_pkg::PLACES_W-1:0]      in_decimal_places,
  output logic                              out_valid,
  output logic [dsr_pkg::WHOLE_W-1:0]       out_root_whole,
  output logic [dsr_pkg::FRACTION_W-1:0]    out_root_fraction
);

  // root grows by one decimal digit (under 4 bits) per place
  localparam int RW  = dsr_pkg::WHOLE_W + 4 * MAX_PLACES;
  // remainder scaled by 100 and the trial increment fit in RW + 8 bits
  localparam int TW  = RW + 8;
  localparam int FW  = 4 * MAX_PLACES;
  localparam int FOW = (FW > dsr_pkg::FRACTION_W) ? FW : dsr_pkg::FRACTION_W;
  localparam int NW  = 2 * dsr_pkg::WHOLE_W;

  dsr_pkg::dsr_state_t state_r, state_nxt;

  logic [NW-1:0]                    n_r, n_nxt;
  logic [RW-1:0]                    root_r, root_nxt;
  logic [TW-1:0]                    rem_r, rem_nxt;
  logic [TW-1:0]                    inc_r, inc_nxt;
  logic [FW-1:0]                    frac_r, frac_nxt;
  logic [dsr_pkg::WHOLE_W-1:0]      whole_r, whole_nxt;
  logic [3:0]                       bit_cnt_r, bit_cnt_nxt;
  logic [3:0]                       digit_r, digit_nxt;
  logic [3:0]                       places_r, places_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [dsr_pkg::WHOLE_W-1:0]      out_whole_r, out_whole_nxt;
  logic [dsr_pkg::FRACTION_W-1:0]   out_frac_r, out_frac_nxt;

  // shared subtract / compare unit
  logic [TW-1:0] alu_a, alu_b;
  logic [TW:0]   alu_diff;
  logic          alu_ge;

  logic [dsr_pkg::WHOLE_W+2:0] root_pair;
  logic [dsr_pkg::WHOLE_W+1:0] root_trial;
  logic [3:0]                  places_in;
  logic [FOW-1:0]              frac_ext;

  assign root_pair  = {rem_r[dsr_pkg::WHOLE_W:0], n_r[NW-1 -: 2]};
  assign root_trial = {root_r[dsr_pkg::WHOLE_W-1:0], 2'b01};

  assign places_in = (4'(in_decimal_places) > 4'(MAX_PLACES)) ?
                     4'(MAX_PLACES) : 4'(in_decimal_places);

  assign frac_ext = FOW'(frac_r);

  always_comb begin
    if (state_r == dsr_pkg::ST_ROOT) begin
      alu_a = TW'(root_pair);
      alu_b = TW'(root_trial);
    end else begin
      alu_a = rem_r;
      alu_b = inc_r;
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = ~alu_diff[TW];
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    inc_nxt       = inc_r;
    frac_nxt      = frac_r;
    whole_nxt     = whole_r;
    bit_cnt_nxt   = bit_cnt_r;
    digit_nxt     = digit_r;
    places_nxt    = places_r;
    out_valid_nxt = 1'b0;
    out_whole_nxt = out_whole_r;
    out_frac_nxt  = out_frac_r;

    case (state_r)
      dsr_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt       = NW'(in_radicand);
          root_nxt    = '0;
          rem_nxt     = '0;
          frac_nxt    = '0;
          places_nxt  = places_in;
          bit_cnt_nxt = 4'(dsr_pkg::ROOT_STEPS - 1);
          state_nxt   = dsr_pkg::ST_ROOT;
        end
      end

      // restoring root: two radicand bits in, one root bit out
      dsr_pkg::ST_ROOT: begin
        n_nxt    = {n_r[NW-3:0], 2'b00};
        root_nxt = {root_r[RW-2:0], alu_ge};
        rem_nxt  = alu_ge ? alu_diff[TW-1:0] : TW'(root_pair);
        bit_cnt_nxt = bit_cnt_r - 4'd1;
        if (bit_cnt_r == 4'd0) begin
          whole_nxt = {root_r[dsr_pkg::WHOLE_W-2:0], alu_ge};
          state_nxt = (places_r == 4'd0) ? dsr_pkg::ST_DONE : dsr_pkg::ST_SETUP;
        end
      end

      // slack = 100*rem, first increment = 20*root + 1
      dsr_pkg::ST_SETUP: begin
        rem_nxt   = (rem_r << 6) + (rem_r << 5) + (rem_r << 2);
        inc_nxt   = (TW'(root_r) << 4) + (TW'(root_r) << 2) + TW'(1);
        digit_nxt = 4'd0;
        state_nxt = dsr_pkg::ST_STEP;
      end

      // need(t+1) - need(t) = 20*root + 2t + 1
      dsr_pkg::ST_STEP: begin
        if (alu_ge) begin
          rem_nxt   = alu_diff[TW-1:0];
          inc_nxt   = inc_r + TW'(2);
          digit_nxt = digit_r + 4'd1;
        end
        if (!alu_ge || digit_r == dsr_pkg::LAST_DIGIT - 4'd1) begin
          state_nxt = dsr_pkg::ST_NEXT;
        end
      end

      dsr_pkg::ST_NEXT: begin
        root_nxt   = (root_r << 3) + (root_r << 1) + RW'(digit_r);
        frac_nxt   = (frac_r << 3) + (frac_r << 1) + FW'(digit_r);
        places_nxt = places_r - 4'd1;
        state_nxt  = (places_r == 4'd1) ? dsr_pkg::ST_DONE : dsr_pkg::ST_SETUP;
      end

      dsr_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_whole_nxt = whole_r;
        out_frac_nxt  = frac_ext[dsr_pkg::FRACTION_W-1:0];
        state_nxt     = dsr_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = dsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      digit_r     <= '0;
      places_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      digit_r     <= digit_nxt;
      places_r    <= places_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    root_r      <= root_nxt;
    rem_r       <= rem_nxt;
    inc_r       <= inc_nxt;
    frac_r      <= frac_nxt;
    whole_r     <= whole_nxt;
    out_whole_r <= out_whole_nxt;
    out_frac_r  <= out_frac_nxt;
  end

  assign busy              = (state_r != dsr_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_root_whole    = out_whole_r;
  assign out_root_fraction = out_frac_r;

  // a result word only follows the output cycle of the sequencer
  a_valid_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == dsr_pkg::ST_DONE))
    else $error("out_valid without a finished word");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsr_pkg::ST_STEP) |-> (digit_r < dsr_pkg::LAST_DIGIT))
    else $error("digit trial ran past nine");

  a_places_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsr_pkg::ST_SETUP || state_r == dsr_pkg::ST_NEXT) |-> (places_r != 4'd0))
    else $error("digit work with no places left");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

endmodule
